### rtl/core/mdio_management_master_macros.svh
// Assertion macros for the MDIO management master.
// No dependencies; included by the modules that carry assertions.
`ifndef MDIO_MANAGEMENT_MASTER_MACROS_SVH
`define MDIO_MANAGEMENT_MASTER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset
`define MM_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define MM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define MM_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define MM_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

### rtl/core/mm_pkg.sv
// Shared types and codes for the MDIO management master.
// No dependencies; used by the interfaces and all modules.
package mm_pkg;

   // Operation codes of a request item
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_WRITE = 2'd2;

   // Frame kind state codes (match the start opcodes)
   localparam logic [1:0] KIND_IDLE  = 2'd0;
   localparam logic [1:0] KIND_READ  = 2'd1;
   localparam logic [1:0] KIND_WRITE = 2'd2;

   // Header patterns: start bits and opcode in the top nibble
   localparam logic [3:0] HDR_READ       = 4'h6;
   localparam logic [3:0] HDR_WRITE      = 4'h5;
   localparam logic [1:0] WRITE_TURNAROUND = 2'h2;

   localparam int unsigned POS_WIDTH = 7;
   localparam int unsigned DATA_WIDTH = 16;
   localparam int unsigned SHIFT_WIDTH = 32;

   typedef logic [POS_WIDTH-1:0] pos_type;

   typedef struct packed {
      logic [1:0]            operation;
      logic                  phy_select;
      logic [4:0]            phy_address;
      logic [4:0]            register_address;
      logic [DATA_WIDTH-1:0] write_data;
      logic                  mdio_in;
   } req_item_type;

   typedef struct packed {
      logic                  mdc;
      logic                  first_mdio_out;
      logic                  first_mdio_drive;
      logic                  second_mdio_out;
      logic                  second_mdio_drive;
      logic                  busy_res;
      logic [DATA_WIDTH-1:0] read_data;
      logic                  read_done;
      logic                  request_dropped;
   } rsp_item_type;

endpackage

### rtl/core/mm_req_if.sv
// Request channel: valid/ready handshake carrying one tick item.
// Depends on mm_pkg.
interface mm_req_if;
   logic                 valid;
   logic                 ready;
   mm_pkg::req_item_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### rtl/core/mm_rsp_if.sv
// Result channel: valid/ready handshake carrying one pin-state item.
// Depends on mm_pkg.
interface mm_rsp_if;
   logic                 valid;
   logic                 ready;
   mm_pkg::rsp_item_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### rtl/core/mm_frame_engine.sv
// Frame engine: frame state registers and the per-tick next-state logic.
// Depends on mm_pkg and mdio_management_master_macros.svh.
`include "mdio_management_master_macros.svh"

module mm_frame_engine #(
   parameter int unsigned PREAMBLE_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_en,
   input  mm_pkg::req_item_type req_item,
   output mm_pkg::rsp_item_type rsp_item
);
   import mm_pkg::*;

   // Frame landmarks in bit positions
   localparam pos_type PreLen     = pos_type'(PREAMBLE_BITS);
   localparam pos_type RdDriveEnd = pos_type'(PREAMBLE_BITS + 14);
   localparam pos_type WrDriveEnd = pos_type'(PREAMBLE_BITS + 32);
   localparam pos_type RdTotal    = pos_type'(PREAMBLE_BITS + 32);
   localparam pos_type WrTotal    = pos_type'(PREAMBLE_BITS + 33);
   localparam pos_type RxFirst    = pos_type'(PREAMBLE_BITS + 16);
   localparam pos_type RxEnd      = pos_type'(PREAMBLE_BITS + 32);

   pos_type                 pos_ff, pos_in;
   logic                    phase_ff, phase_in;
   logic [1:0]              kind_ff, kind_in;
   logic                    pin_ff, pin_in;
   logic [SHIFT_WIDTH-1:0]  tx_ff, tx_in;
   logic [DATA_WIDTH-1:0]   rx_ff, rx_in;
   logic [3:0]              levels_ff, levels_in;

   logic start_req;

   assign start_req = (req_item.operation == OP_READ) || (req_item.operation == OP_WRITE);

   // Compute next frame state and this tick's result
   always_comb begin
      logic       rd;
      logic       data_bit;
      logic       busy;
      logic       done;
      logic       dropped;
      logic [1:0] sh;
      pos_type    drive_end;
      pos_type    total;
      pos_type    pos_next;

      kind_in   = kind_ff;
      pin_in    = pin_ff;
      pos_in    = pos_ff;
      phase_in  = phase_ff;
      tx_in     = tx_ff;
      rx_in     = rx_ff;
      levels_in = levels_ff;
      busy      = 1'b0;
      done      = 1'b0;
      dropped   = 1'b0;
      rd        = 1'b0;
      data_bit  = 1'b0;
      sh        = 2'd0;
      drive_end = WrDriveEnd;
      total     = WrTotal;
      pos_next  = pos_ff;

      // Load a new frame when idle, flag a request while busy
      if (kind_ff == KIND_IDLE) begin
         if (start_req) begin
            kind_in  = req_item.operation;
            pin_in   = req_item.phy_select;
            pos_in   = '0;
            phase_in = 1'b0;
            if (req_item.operation == OP_READ) begin
               tx_in = {HDR_READ, req_item.phy_address, req_item.register_address, 18'd0};
            end else begin
               tx_in = {HDR_WRITE, req_item.phy_address, req_item.register_address,
                        WRITE_TURNAROUND, req_item.write_data};
            end
         end
      end else if (start_req) begin
         dropped = 1'b1;
      end

      // Advance the active frame by one half bit
      if (kind_in != KIND_IDLE) begin
         rd        = (kind_in == KIND_READ);
         drive_end = rd ? RdDriveEnd : WrDriveEnd;
         total     = rd ? RdTotal : WrTotal;
         data_bit  = (pos_in >= PreLen) && (pos_in < drive_end);
         busy      = 1'b1;
         sh        = {pin_in, 1'b0};

         if (pos_in < PreLen) begin
            levels_in[sh]      = 1'b1;
            levels_in[sh+2'd1] = 1'b1;
         end else if (data_bit) begin
            levels_in[sh]      = tx_in[SHIFT_WIDTH-1];
            levels_in[sh+2'd1] = 1'b1;
         end else begin
            levels_in[sh+2'd1] = 1'b0;
         end

         // Sample read data just after MDC falls
         if (rd && !phase_in && (pos_in >= RxFirst) && (pos_in < RxEnd)) begin
            rx_in = {rx_ff[DATA_WIDTH-2:0], req_item.mdio_in};
         end

         if (phase_in) begin
            if (data_bit) begin
               tx_in = {tx_in[SHIFT_WIDTH-2:0], 1'b0};
            end
            pos_next = pos_in + pos_type'(1);
            if (pos_next >= total) begin
               done     = rd;
               kind_in  = KIND_IDLE;
               pos_next = '0;
            end
            pos_in   = pos_next;
            phase_in = 1'b0;
         end else begin
            phase_in = 1'b1;
         end
      end

      rsp_item.mdc               = busy & phase_ff & (kind_ff != KIND_IDLE);
      rsp_item.first_mdio_out    = levels_in[0];
      rsp_item.first_mdio_drive  = levels_in[1];
      rsp_item.second_mdio_out   = levels_in[2];
      rsp_item.second_mdio_drive = levels_in[3];
      rsp_item.busy_res          = busy;
      rsp_item.read_data         = rx_in;
      rsp_item.read_done         = done;
      rsp_item.request_dropped   = dropped;
   end

   // Hold state between accepted items
   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff   <= KIND_IDLE;
         pin_ff    <= 1'b0;
         pos_ff    <= '0;
         phase_ff  <= 1'b0;
         tx_ff     <= '0;
         rx_ff     <= '0;
         levels_ff <= '0;
      end else if (step_en) begin
         kind_ff   <= kind_in;
         pin_ff    <= pin_in;
         pos_ff    <= pos_in;
         phase_ff  <= phase_in;
         tx_ff     <= tx_in;
         rx_ff     <= rx_in;
         levels_ff <= levels_in;
      end
   end

   `MM_ASSERT_IMPLY(a_idle_aligned, clock, reset, kind_ff == KIND_IDLE, (!phase_ff) && (pos_ff == '0), "idle frame with nonzero position")
   `MM_ASSERT_NEXT(a_phase_toggle, clock, reset, step_en && phase_ff, !phase_ff, "high half not followed by low half")
   `MM_ASSERT_IMPLY(a_done_on_read, clock, reset, rsp_item.read_done, (kind_ff == KIND_READ) && phase_ff, "read done outside read high half")
   `MM_ASSERT_IMPLY(a_drop_busy, clock, reset, rsp_item.request_dropped, kind_ff != KIND_IDLE, "request dropped while idle")

endmodule

### rtl/core/mm_output_stage.sv
// Output register: holds one finished item until the result channel takes it.
// Depends on mm_pkg and mm_rsp_if.
module mm_output_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load_en,
   input  mm_pkg::rsp_item_type result_item,
   output logic                 accept_ok,
   mm_rsp_if.source             rsp_if
);
   import mm_pkg::*;

   logic         valid_ff, valid_in;
   rsp_item_type item_ff;

   // Take a new item when empty or when the held one leaves this cycle
   assign accept_ok = !valid_ff || rsp_if.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load_en) begin
         valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset
   always_ff @(posedge clock) begin
      if (load_en) begin
         item_ff <= result_item;
      end
   end

   assign rsp_if.valid   = valid_ff;
   assign rsp_if.payload = item_ff;

endmodule

### rtl/core/mdio_management_master.sv
// Latency: a result item is valid the cycle after its request item is accepted.
// Throughput: one tick item per cycle, set by the single-pass frame engine
// feeding one output register; a request is taken whenever that register is
// empty or being emptied.
// Reset: synchronous; frame goes idle, both MDIO pins released low, output empty.
module mdio_management_master #(
   parameter int unsigned PREAMBLE_BITS = 32
) (
   input logic      clock,
   input logic      reset,
   mm_req_if.sink   req_if,
   mm_rsp_if.source rsp_if
);
   import mm_pkg::*;

   rsp_item_type result_item;
   logic         accept_ok;
   logic         step_en;

   // Accept a tick when the output register can take its result
   assign req_if.ready = accept_ok;
   assign step_en      = req_if.valid && accept_ok;

   mm_frame_engine #(
      .PREAMBLE_BITS (PREAMBLE_BITS)
   ) u_engine (
      .clock    (clock),
      .reset    (reset),
      .step_en  (step_en),
      .req_item (req_if.payload),
      .rsp_item (result_item)
   );

   mm_output_stage u_output (
      .clock       (clock),
      .reset       (reset),
      .load_en     (step_en),
      .result_item (result_item),
      .accept_ok   (accept_ok),
      .rsp_if      (rsp_if)
   );

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Testbench for the MDIO management master: drives tick items, predicts every pin-state item.
// Depends on mm_pkg, mm_req_if, mm_rsp_if and mdio_management_master.
module tb_top;
   import mm_pkg::*;

   localparam int unsigned PREAMBLE     = 32;
   localparam logic [1:0]  OP_UNUSED    = 2'd3;
   localparam int          RANDOM_ITEMS = 650;
   localparam int          QUIET_FROM   = 300;
   localparam int          QUIET_TO     = 380;
   localparam int          TAIL_FROM    = 550;
   localparam int          STALL_AT     = 200;
   localparam int          STALL_CYCLES = 60;
   localparam int          PAUSE_AT     = 450;

   typedef struct {
      req_item_type item;
      bit           has_want;
      rsp_item_type want;
   } dir_row_type;

   logic clock;
   logic reset;

   mm_req_if req_ch ();
   mm_rsp_if rsp_ch ();

   mdio_management_master #(
      .PREAMBLE_BITS(PREAMBLE)
   ) DUT (
      .clock (clock),
      .reset (reset),
      .req_if(req_ch),
      .rsp_if(rsp_ch)
   );

   // Frame engine copy, at reset values
   logic [1:0]  frm_kind = KIND_IDLE;
   logic        frm_pin  = 1'b0;
   pos_type     frm_pos  = '0;
   logic        frm_half = 1'b0;
   logic [31:0] frm_tx   = '0;
   logic [15:0] frm_rx   = '0;
   logic [3:0]  frm_pins = '0;

   rsp_item_type pin_state_q[$];
   dir_row_type  dir_rows[$];
   int           fails = 0;
   bit           idle_on = 1'b1;
   bit           stall_asked = 1'b0;

   // Clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Run limit
   initial begin
      #2_000_000;
      $display("[mdio_management_master] ERROR");
      $finish;
   end

   // Drive or release the pin addressed by the current frame
   function automatic void drive_pin(logic drive, logic level);
      if (frm_pin) begin
         if (drive) frm_pins[3:2] = {1'b1, level};
         else frm_pins[3] = 1'b0;
      end else begin
         if (drive) frm_pins[1:0] = {1'b1, level};
         else frm_pins[1] = 1'b0;
      end
   endfunction

   // Advance the frame by one half-bit tick and return the pin state it shows
   function automatic rsp_item_type advance_frame(req_item_type it);
      rsp_item_type r;
      logic         start;
      logic         rd;
      logic         data_bit;
      int unsigned  pos;
      int unsigned  drive_end;
      int unsigned  total;
      r = '0;
      start = (it.operation == OP_READ) || (it.operation == OP_WRITE);
      if (frm_kind == KIND_IDLE) begin
         if (start) begin
            frm_kind = it.operation;
            frm_pin  = it.phy_select;
            frm_pos  = '0;
            frm_half = 1'b0;
            if (it.operation == OP_READ)
               frm_tx = {HDR_READ, it.phy_address, it.register_address, 18'd0};
            else
               frm_tx = {HDR_WRITE, it.phy_address, it.register_address,
                         WRITE_TURNAROUND, it.write_data};
         end
      end else if (start) begin
         r.request_dropped = 1'b1;
      end

      if (frm_kind != KIND_IDLE) begin
         rd        = (frm_kind == KIND_READ);
         pos       = 32'(frm_pos);
         drive_end = rd ? PREAMBLE + 14 : PREAMBLE + 32;
         total     = rd ? PREAMBLE + 32 : PREAMBLE + 33;
         data_bit  = (pos >= PREAMBLE) && (pos < drive_end);
         r.busy_res = 1'b1;
         r.mdc      = frm_half;

         // Preamble ones, then header and data, then released
         if (pos < PREAMBLE) drive_pin(1'b1, 1'b1);
         else if (data_bit) drive_pin(1'b1, frm_tx[31]);
         else drive_pin(1'b0, 1'b0);

         // Capture read data in the low half after MDC falls
         if (rd && !frm_half && pos >= PREAMBLE + 16 && pos <= PREAMBLE + 31)
            frm_rx = {frm_rx[14:0], it.mdio_in};

         if (frm_half) begin
            if (data_bit) frm_tx = frm_tx << 1;
            pos++;
            if (pos >= total) begin
               if (rd) r.read_done = 1'b1;
               frm_kind = KIND_IDLE;
               pos = 0;
            end
            frm_pos  = pos_type'(pos);
            frm_half = 1'b0;
         end else begin
            frm_half = 1'b1;
         end
      end

      r.first_mdio_out    = frm_pins[0];
      r.first_mdio_drive  = frm_pins[1];
      r.second_mdio_out   = frm_pins[2];
      r.second_mdio_drive = frm_pins[3];
      r.read_data         = frm_rx;
      return r;
   endfunction

   function automatic req_item_type mk_item(logic [1:0] op, logic sel, logic [4:0] pa,
                                            logic [4:0] ra, logic [15:0] wd, logic din);
      req_item_type it;
      it.operation        = op;
      it.phy_select       = sel;
      it.phy_address      = pa;
      it.register_address = ra;
      it.write_data       = wd;
      it.mdio_in          = din;
      return it;
   endfunction

   function automatic rsp_item_type mk_pins(logic mdc, logic fo, logic fd, logic so, logic sd,
                                            logic busy, logic [15:0] rdata, logic done,
                                            logic drop);
      rsp_item_type r;
      r.mdc               = mdc;
      r.first_mdio_out    = fo;
      r.first_mdio_drive  = fd;
      r.second_mdio_out   = so;
      r.second_mdio_drive = sd;
      r.busy_res          = busy;
      r.read_data         = rdata;
      r.read_done         = done;
      r.request_dropped   = drop;
      return r;
   endfunction

   // Address with a bias toward the extremes
   function automatic logic [4:0] pick_addr();
      case ($urandom_range(0, 3))
         0: return 5'd0;
         1: return 5'd31;
         default: return 5'($urandom);
      endcase
   endfunction

   // Mostly well-formed frames: start when idle, tick while busy, some noise
   function automatic req_item_type next_tick_item();
      req_item_type it;
      int           r;
      r = $urandom_range(0, 99);
      it = mk_item(OP_TICK, 1'($urandom), pick_addr(), pick_addr(), 16'($urandom),
                   1'($urandom));
      case ($urandom_range(0, 3))
         0: it.write_data = 16'h0000;
         1: it.write_data = 16'hFFFF;
         default: ;
      endcase
      if (frm_kind == KIND_IDLE) begin
         if (r < 40) it.operation = OP_READ;
         else if (r < 80) it.operation = OP_WRITE;
         else if (r < 90) it.operation = OP_TICK;
         else it.operation = OP_UNUSED;
      end else begin
         if (r < 94) it.operation = OP_TICK;
         else if (r < 97) it.operation = $urandom_range(0, 1) ? OP_READ : OP_WRITE;
         else it.operation = OP_UNUSED;
      end
      return it;
   endfunction

   // Offer one item, hold it until taken, then record what it must produce
   task automatic offer_tick(req_item_type it, bit has_want, rsp_item_type want);
      rsp_item_type predicted;
      @(negedge clock);
      req_ch.valid   <= 1'b1;
      req_ch.payload <= it;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predicted = advance_frame(it);
      pin_state_q.push_back(has_want ? want : predicted);
   endtask

   task automatic hold_valid_low(int n);
      repeat (n) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
      end
   endtask

   task automatic compare_pins(rsp_item_type want, rsp_item_type got);
      if (got.mdc !== want.mdc) begin
         $error("mdc: expected %0h, actual %0h", want.mdc, got.mdc);
         fails++;
      end
      if (got.first_mdio_out !== want.first_mdio_out) begin
         $error("first_mdio_out: expected %0h, actual %0h",
                want.first_mdio_out, got.first_mdio_out);
         fails++;
      end
      if (got.first_mdio_drive !== want.first_mdio_drive) begin
         $error("first_mdio_drive: expected %0h, actual %0h",
                want.first_mdio_drive, got.first_mdio_drive);
         fails++;
      end
      if (got.second_mdio_out !== want.second_mdio_out) begin
         $error("second_mdio_out: expected %0h, actual %0h",
                want.second_mdio_out, got.second_mdio_out);
         fails++;
      end
      if (got.second_mdio_drive !== want.second_mdio_drive) begin
         $error("second_mdio_drive: expected %0h, actual %0h",
                want.second_mdio_drive, got.second_mdio_drive);
         fails++;
      end
      if (got.busy_res !== want.busy_res) begin
         $error("busy_res: expected %0h, actual %0h", want.busy_res, got.busy_res);
         fails++;
      end
      if (got.read_data !== want.read_data) begin
         $error("read_data: expected %0h, actual %0h", want.read_data, got.read_data);
         fails++;
      end
      if (got.read_done !== want.read_done) begin
         $error("read_done: expected %0h, actual %0h", want.read_done, got.read_done);
         fails++;
      end
      if (got.request_dropped !== want.request_dropped) begin
         $error("request_dropped: expected %0h, actual %0h",
                want.request_dropped, got.request_dropped);
         fails++;
      end
   endtask

   // Check each accepted pin-state item against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pin_state_q.size() == 0) begin
            $error("pin state item with no expectation waiting: %0h", rsp_ch.payload);
            fails++;
         end else begin
            compare_pins(pin_state_q.pop_front(), rsp_ch.payload);
         end
      end
   end

   // Receiver: random hold-off bursts, one long stall on request
   initial begin
      int stall_left;
      int gap_left;
      bit stall_taken;
      stall_left  = 0;
      gap_left    = 0;
      stall_taken = 1'b0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_asked && !stall_taken) begin
            stall_taken = 1'b1;
            stall_left  = STALL_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (gap_left > 0) begin
            gap_left--;
            rsp_ch.ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 9) == 0) begin
            gap_left = $urandom_range(1, 7) - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Sender: reset, directed table, then random frames
   initial begin
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.payload = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Idle tick and the unused operation with every field high show nothing
      dir_rows.push_back('{mk_item(OP_TICK, 1'b0, 5'd0, 5'd0, 16'h0000, 1'b0), 1'b1,
                           mk_pins(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000,
                                   1'b0, 1'b0)});
      dir_rows.push_back('{mk_item(OP_UNUSED, 1'b1, 5'd31, 5'd31, 16'hFFFF, 1'b1), 1'b1,
                           mk_pins(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000,
                                   1'b0, 1'b0)});
      // Read start on the second pin drives the first preamble bit at once
      dir_rows.push_back('{mk_item(OP_READ, 1'b1, 5'd0, 5'd0, 16'h0000, 1'b1), 1'b1,
                           mk_pins(1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 16'h0000,
                                   1'b0, 1'b0)});
      // Requests while busy are dropped
      dir_rows.push_back('{mk_item(OP_WRITE, 1'b0, 5'd31, 5'd31, 16'hFFFF, 1'b0), 1'b1,
                           mk_pins(1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 16'h0000,
                                   1'b0, 1'b1)});
      dir_rows.push_back('{mk_item(OP_READ, 1'b0, 5'd31, 5'd0, 16'h0000, 1'b0), 1'b1,
                           mk_pins(1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 16'h0000,
                                   1'b0, 1'b1)});
      // Unused operation while busy is not flagged
      dir_rows.push_back('{mk_item(OP_UNUSED, 1'b0, 5'd0, 5'd31, 16'h0000, 1'b1), 1'b0,
                           '0});
      for (int i = 0; i < 18; i++) begin
         dir_rows.push_back('{mk_item(OP_TICK, 1'(i), 5'(i), 5'(31 - i),
                                      i[0] ? 16'hFFFF : 16'h0000, 1'(i >> 1)), 1'b0, '0});
      end

      foreach (dir_rows[i]) begin
         if ($urandom_range(0, 5) == 0) hold_valid_low($urandom_range(1, 7));
         offer_tick(dir_rows[i].item, dir_rows[i].has_want, dir_rows[i].want);
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         idle_on = !((n >= QUIET_FROM && n < QUIET_TO) || n >= TAIL_FROM);
         // Keep offering through the long receiver stall
         if (n == STALL_AT) stall_asked = 1'b1;
         // Pause until every expected item has drained
         if (n == PAUSE_AT) begin
            do hold_valid_low(1); while (pin_state_q.size() != 0);
         end
         if (idle_on && !(n >= STALL_AT && n < STALL_AT + STALL_CYCLES)
             && $urandom_range(0, 5) == 0)
            hold_valid_low($urandom_range(1, 7));
         offer_tick(next_tick_item(), 1'b0, '0);
      end

      // Drain, then let the output register settle
      idle_on = 1'b0;
      do hold_valid_low(1); while (pin_state_q.size() != 0);
      repeat (10) @(posedge clock);
      if (fails == 0)
         $display("[mdio_management_master] OK");
      else
         $display("[mdio_management_master] ERROR");
      $finish;
   end

endmodule
